// ----- hw/rtl/ttlrc_pkg.sv -----
// Package for the TTL record cache table: payload structs, result codes and
// the table size. Used by every module of the block.
`timescale 1ns / 1ps
`default_nettype none
package ttlrc_pkg;

  localparam int unsigned Entries = 64;
  localparam int unsigned IdxW    = $clog2(Entries);
  localparam int unsigned StartW  = 7;

  localparam logic [1:0] ResStored = 2'd0;
  localparam logic [1:0] ResFull   = 2'd1;
  localparam logic [1:0] ResFound  = 2'd2;
  localparam logic [1:0] ResMiss   = 2'd3;

  localparam logic [1:0] OriginFile = 2'd0;
  localparam logic       ReqStore   = 1'b0;

  typedef struct packed {
    logic        req_type;
    logic [31:0] now_seconds;
    logic [63:0] name_key;
    logic [3:0]  record_type;
    logic [1:0]  record_origin;
    logic [63:0] address_high;
    logic [63:0] address_low;
    logic [31:0] ttl_seconds;
    logic [15:0] priority_req;
    logic [6:0]  start_index;
  } req_t;

  typedef struct packed {
    logic [1:0]  result_code;
    logic [5:0]  found_index;
    logic [63:0] found_address_high;
    logic [63:0] found_address_low;
    logic [31:0] found_ttl;
  } rsp_t;

  // One stored record.
  typedef struct packed {
    logic        valid;
    logic [63:0] name_key;
    logic [63:0] address_high;
    logic [63:0] address_low;
    logic [3:0]  rtype;
    logic [1:0]  origin;
    logic [31:0] ttl;
    logic [31:0] stamp;
    logic [15:0] prio;
  } rec_t;

  // Per-cycle instruction to the cell at the head of the ring.
  typedef struct packed {
    logic expire;   // clear valid bit of the head record
    logic refresh;  // rewrite TTL and stamp
    logic fill;     // write whole record from the request
  } cell_ctl_t;

endpackage
`default_nettype wire

// ----- hw/rtl/ttlrc_cell.sv -----
// One cell of the record ring: holds a single record and passes it on to its
// neighbour each rotate cycle. Depends on ttlrc_pkg.
`timescale 1ns / 1ps
`default_nettype none
module ttlrc_cell
  import ttlrc_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic shift_i,
  input  wire rec_t rec_i,
  output rec_t      rec_o
);

  rec_t rec_q;
  logic valid_q;

  // The valid bit resets; the payload does not.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (shift_i) begin
      valid_q <= rec_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      rec_q <= rec_i;
    end
  end

  always_comb begin
    rec_o       = rec_q;
    rec_o.valid = valid_q;
  end

endmodule
`default_nettype wire

// ----- hw/rtl/ttlrc_head.sv -----
// Head of the ring: applies expiry, refresh or fill to the record passing
// from the last cell back to the first. Depends on ttlrc_pkg.
`timescale 1ns / 1ps
`default_nettype none
module ttlrc_head
  import ttlrc_pkg::*;
(
  input  wire rec_t      rec_i,
  input  wire req_t      req_i,
  input  wire cell_ctl_t ctl_i,
  output rec_t           rec_o
);

  always_comb begin
    rec_o = rec_i;
    if (ctl_i.fill) begin
      rec_o.valid        = 1'b1;
      rec_o.name_key     = req_i.name_key;
      rec_o.address_high = req_i.address_high;
      rec_o.address_low  = req_i.address_low;
      rec_o.rtype        = req_i.record_type;
      rec_o.origin       = req_i.record_origin;
      rec_o.ttl          = req_i.ttl_seconds;
      rec_o.stamp        = req_i.now_seconds;
      rec_o.prio         = req_i.priority_req;
    end else if (ctl_i.refresh) begin
      rec_o.ttl   = req_i.ttl_seconds;
      rec_o.stamp = req_i.now_seconds;
    end else if (ctl_i.expire) begin
      rec_o.valid = 1'b0;
    end
  end

endmodule
`default_nettype wire

// ----- hw/rtl/ttl_record_cache_table.sv -----
// TTL record cache table: an accepted request passes the states scan, fill
// and done, and the result is registered after done. The run time is set by
// the ring of record cells, which rotates once fully to scan and once more
// for a fill. busy is high from the accepting edge through the done state.
// The single result then appears on rsp_o with rsp_valid_o high for exactly
// one cycle, and a new request may already be accepted in that cycle; the
// receiver cannot stall the result. Entry i sits at the head when the
// rotation count equals i. Depends on ttlrc_pkg, ttlrc_cell and ttlrc_head.
`timescale 1ns / 1ps
`default_nettype none
module ttl_record_cache_table
  import ttlrc_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic start,
  output logic      busy,
  input  wire req_t req_i,
  output logic      rsp_valid_o,
  output rsp_t      rsp_o
);

  typedef enum logic [3:0] {
    StIdle = 4'b0001,
    StScan = 4'b0010,
    StFill = 4'b0100,
    StDone = 4'b1000
  } state_e;

  state_e state_q, state_d;
  req_t   req_q;
  logic [IdxW:0]   cnt_q, cnt_d;
  logic            free_q, free_d, hit_q, hit_d, stop_q, stop_d;
  logic [IdxW-1:0] slot_q, slot_d;
  rsp_t   rsp_q, rsp_d;
  logic   rsp_valid_q;

  rec_t ring [Entries];
  rec_t head_in;
  rec_t head_out;
  cell_ctl_t ctl;
  logic shift;
  logic [IdxW-1:0] pos;
  logic [31:0] age;
  logic timed_out, lk_match, st_match;

  assign shift = (state_q == StScan) || (state_q == StFill);
  assign head_in = ring[Entries-1];
  assign pos = cnt_q[IdxW-1:0];

  for (genvar g = 0; g < Entries; g++) begin : g_cells
    ttlrc_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .shift_i(shift),
      .rec_i  (g == 0 ? head_out : ring[(g == 0) ? 0 : g-1]),
      .rec_o  (ring[g])
    );
  end

  ttlrc_head u_head (
    .rec_i(head_in),
    .req_i(req_q),
    .ctl_i(ctl),
    .rec_o(head_out)
  );

  assign age       = req_q.now_seconds - head_in.stamp;
  assign timed_out = head_in.valid && (head_in.origin != OriginFile) && (age > head_in.ttl);
  assign lk_match  = head_in.valid && !timed_out && head_in.name_key == req_q.name_key
                     && head_in.rtype == req_q.record_type;
  assign st_match  = head_in.valid && (req_q.record_origin != OriginFile)
                     && head_in.name_key == req_q.name_key
                     && head_in.rtype == req_q.record_type
                     && head_in.prio == req_q.priority_req
                     && head_in.address_high == req_q.address_high
                     && head_in.address_low == req_q.address_low;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    free_d  = free_q;
    hit_d   = hit_q;
    stop_d  = stop_q;
    slot_d  = slot_q;
    rsp_d   = rsp_q;
    ctl     = '0;
    case (state_q)
      StIdle: begin
        if (start) begin
          state_d = StScan;
          cnt_d   = '0;
          free_d  = 1'b0;
          hit_d   = 1'b0;
          stop_d  = 1'b0;
          slot_d  = '0;
          rsp_d   = '0;
        end
      end
      StScan: begin
        // A full turn always; decisions stop at a hit or a file store's free slot.
        if (!stop_q) begin
          if (req_q.req_type == ReqStore) begin
            if (!head_in.valid) begin
              if (!free_q) begin
                free_d = 1'b1;
                slot_d = pos;
              end
              if (req_q.record_origin == OriginFile) stop_d = 1'b1;
            end else if (st_match) begin
              ctl.refresh = 1'b1;
              hit_d  = 1'b1;
              stop_d = 1'b1;
            end
          end else if ({1'b0, pos} >= {1'b0, req_q.start_index[IdxW-1:0]}
                       && req_q.start_index < StartW'(Entries)) begin
            if (timed_out) begin
              ctl.expire = 1'b1;
            end else if (lk_match) begin
              hit_d  = 1'b1;
              stop_d = 1'b1;
              rsp_d.found_index        = 6'(pos);
              rsp_d.found_address_high = head_in.address_high;
              rsp_d.found_address_low  = head_in.address_low;
              rsp_d.found_ttl          = head_in.ttl;
            end
          end
        end
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == (IdxW+1)'(Entries-1)) begin
          cnt_d   = '0;
          state_d = StFill;
        end
      end
      StFill: begin
        if (req_q.req_type == ReqStore && !hit_q && free_q && pos == slot_q) ctl.fill = 1'b1;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == (IdxW+1)'(Entries-1)) begin
          state_d = StDone;
          if (req_q.req_type == ReqStore)
            rsp_d.result_code = (hit_q || free_q) ? ResStored : ResFull;
          else
            rsp_d.result_code = hit_q ? ResFound : ResMiss;
        end
      end
      StDone: state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      cnt_q       <= '0;
      free_q      <= 1'b0;
      hit_q       <= 1'b0;
      stop_q      <= 1'b0;
      slot_q      <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      free_q      <= free_d;
      hit_q       <= hit_d;
      stop_q      <= stop_d;
      slot_q      <= slot_d;
      rsp_valid_q <= (state_q == StDone);
    end
  end

  always_ff @(posedge clk_i) begin
    rsp_q <= rsp_d;
    if (state_q == StIdle && start) req_q <= req_i;
  end

  assign busy        = (state_q != StIdle);
  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

  // A result follows only the end of a request.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o |-> $past(state_q) == StDone)
    else $error("result without finished request");
  // Only one head action at a time.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({ctl.fill, ctl.refresh, ctl.expire}))
    else $error("conflicting head actions");
  // A fill only targets a free record.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl.fill |-> !head_in.valid)
    else $error("fill over a valid record");

endmodule
`default_nettype wire

// ----- dv/ttl_record_cache_table_checker.sv -----
// Checker for the TTL record cache table: watches the request and response
// channels, keeps its own copy of the record table and compares every response.
// Depends on ttlrc_pkg.
`timescale 1ns / 1ps
module ttl_record_cache_table_checker
  import ttlrc_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  input  logic busy,
  input  req_t req_i,
  input  logic rsp_valid_o,
  input  rsp_t rsp_o,
  output int   fail_count,
  output int   pending,
  output int   hit_count,
  output int   full_count,
  output int   expire_count,
  output int   refresh_count
);

  rec_t records[Entries];
  rsp_t expected_rsps[$];

  task automatic report_mismatch(input string field, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("%0t: mismatch on %s: got %0h, expected %0h", $time, field, got, want);
    fail_count++;
  endtask

  function automatic logic [1:0] apply_store(input req_t r);
    int free_slot;
    free_slot = -1;
    for (int i = 0; i < Entries; i++) begin
      if (!records[i].valid) begin
        if (free_slot < 0) free_slot = i;
        if (r.record_origin == OriginFile) break;
      end else if (r.record_origin != OriginFile && records[i].name_key == r.name_key &&
                   records[i].rtype == r.record_type && records[i].prio == r.priority_req &&
                   records[i].address_high == r.address_high &&
                   records[i].address_low == r.address_low) begin
        // A refresh touches only the TTL and the stamp; the origin is kept.
        records[i].stamp = r.now_seconds;
        records[i].ttl   = r.ttl_seconds;
        refresh_count++;
        return ResStored;
      end
    end
    if (free_slot < 0) begin
      full_count++;
      return ResFull;
    end
    records[free_slot] = '{valid: 1'b1, name_key: r.name_key,
                           address_high: r.address_high, address_low: r.address_low,
                           rtype: r.record_type, origin: r.record_origin,
                           ttl: r.ttl_seconds, stamp: r.now_seconds,
                           prio: r.priority_req};
    return ResStored;
  endfunction

  function automatic rsp_t predict_response(input req_t r);
    rsp_t res;
    logic [31:0] age;
    res = '0;
    res.result_code = ResMiss;
    if (r.req_type == ReqStore) begin
      res.result_code = apply_store(r);
      return res;
    end
    for (int i = int'(r.start_index); i < Entries; i++) begin
      if (records[i].valid) begin
        age = r.now_seconds - records[i].stamp;
        if (records[i].origin != OriginFile && age > records[i].ttl) begin
          records[i].valid = 1'b0;
          expire_count++;
        end else if (records[i].name_key == r.name_key &&
                     records[i].rtype == r.record_type) begin
          res.result_code        = ResFound;
          res.found_index        = i[5:0];
          res.found_address_high = records[i].address_high;
          res.found_address_low  = records[i].address_low;
          res.found_ttl          = records[i].ttl;
          hit_count++;
          break;
        end
      end
    end
    return res;
  endfunction

  initial begin
    fail_count = 0; hit_count = 0; full_count = 0; expire_count = 0; refresh_count = 0;
    foreach (records[i]) records[i] = '0;
  end

  assign pending = expected_rsps.size();

  always @(posedge clk_i) begin
    rsp_t want;
    if (rst_ni) begin
      if (rsp_valid_o) begin
        if (expected_rsps.size() == 0) begin
          $display("%0t: response with no request outstanding", $time);
          fail_count++;
        end else begin
          want = expected_rsps.pop_front();
          if (rsp_o.result_code !== want.result_code)
            report_mismatch("result_code", rsp_o.result_code, want.result_code);
          if (rsp_o.found_index !== want.found_index)
            report_mismatch("found_index", rsp_o.found_index, want.found_index);
          if (rsp_o.found_address_high !== want.found_address_high)
            report_mismatch("found_address_high", rsp_o.found_address_high,
                            want.found_address_high);
          if (rsp_o.found_address_low !== want.found_address_low)
            report_mismatch("found_address_low", rsp_o.found_address_low,
                            want.found_address_low);
          if (rsp_o.found_ttl !== want.found_ttl)
            report_mismatch("found_ttl", rsp_o.found_ttl, want.found_ttl);
        end
      end
      if (start && !busy) expected_rsps.push_back(predict_response(req_i));
    end
  end

endmodule

// ----- dv/ttl_record_cache_table_tb.sv -----
// Testbench top for the TTL record cache table: clock, reset, request
// stimulus and the verdict. Depends on ttlrc_pkg, the block and its checker.
`timescale 1ns / 1ps
module ttl_record_cache_table_tb;
  import ttlrc_pkg::*;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  req_t req_i = '0;
  logic rsp_valid_o;
  rsp_t rsp_o;
  int   fail_count, pending, hit_count, full_count, expire_count, refresh_count;

  logic [31:0] clock_now = 32'd1000;
  logic [63:0] name_pool[8];
  logic [63:0] addr_pool[4];
  int          fill_bursts = 0;

  ttl_record_cache_table dut (
    .clk_i, .rst_ni, .start, .busy, .req_i, .rsp_valid_o, .rsp_o
  );

  ttl_record_cache_table_checker checker_i (
    .clk_i, .rst_ni, .start, .busy, .req_i, .rsp_valid_o, .rsp_o,
    .fail_count, .pending, .hit_count, .full_count, .expire_count, .refresh_count
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  initial begin
    #10_000_000;
    $display("TB_ERROR");
    $finish;
  end

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  task automatic send(input req_t r, input bit allow_gap);
    @(negedge clk_i);
    if (allow_gap) repeat ($urandom_range(0, 7)) @(negedge clk_i);
    while (busy) @(negedge clk_i);
    start <= 1'b1;
    req_i <= r;
    @(negedge clk_i);
    start <= 1'b0;
  endtask

  task automatic drain();
    while (pending != 0) @(negedge clk_i);
    repeat (140) @(negedge clk_i);
  endtask

  function automatic req_t make_req(input logic rt, input logic [63:0] name,
                                    input logic [3:0] typ, input logic [1:0] origin,
                                    input logic [63:0] ah, input logic [63:0] al,
                                    input logic [31:0] ttl, input logic [15:0] prio,
                                    input logic [6:0] first);
    req_t r;
    r = '{req_type: rt, now_seconds: clock_now, name_key: name, record_type: typ,
          record_origin: origin, address_high: ah, address_low: al, ttl_seconds: ttl,
          priority_req: prio, start_index: first};
    return r;
  endfunction

  function automatic req_t random_req();
    logic [63:0] name, ah, al;
    logic [31:0] ttl;
    logic [3:0]  typ;
    logic [1:0]  origin;
    logic [6:0]  first;
    if ($urandom_range(0, 99) < 3) clock_now = $urandom();
    else clock_now += $urandom_range(0, 8);
    name  = ($urandom_range(0, 9) < 8) ? name_pool[$urandom_range(0, 7)] : rand64();
    ah    = ($urandom_range(0, 9) < 8) ? addr_pool[$urandom_range(0, 3)] : rand64();
    al    = ($urandom_range(0, 9) < 8) ? ~addr_pool[$urandom_range(0, 3)] : rand64();
    typ   = ($urandom_range(0, 9) < 8) ? 4'($urandom_range(0, 2)) : 4'($urandom());
    ttl   = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 60) : $urandom();
    // Config-file records never leave the table, so they are kept rare.
    origin = ($urandom_range(0, 99) < 3) ? OriginFile : 2'($urandom_range(1, 3));
    first  = ($urandom_range(0, 9) < 7) ? 7'd0 : 7'($urandom_range(0, 127));
    return make_req(1'($urandom_range(0, 1)), name, typ, origin, ah, al, ttl,
                    16'($urandom_range(0, 3) == 0 ? $urandom() : $urandom_range(0, 1)),
                    first);
  endfunction

  initial begin
    req_t r;
    foreach (name_pool[i]) name_pool[i] = rand64();
    foreach (addr_pool[i]) addr_pool[i] = rand64();
    name_pool[0] = '1;
    name_pool[1] = '0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed part: extremes, refresh, origin three, start beyond the table,
    // wrapping expiry.
    send(make_req(ReqStore, '1, 4'hF, OriginFile, '1, '1, '1, '1, 7'd0), 1'b0);
    send(make_req(~ReqStore, '1, 4'hF, OriginFile, '0, '0, '0, '0, 7'd0), 1'b0);
    send(make_req(~ReqStore, '1, 4'hF, OriginFile, '0, '0, '0, '0, 7'd127), 1'b0);
    send(make_req(~ReqStore, '1, 4'hF, OriginFile, '0, '0, '0, '0, 7'd64), 1'b0);
    send(make_req(ReqStore, '0, 4'h0, 2'd1, '0, '0, 32'd5, '0, 7'd0), 1'b0);
    clock_now += 3;
    send(make_req(ReqStore, '0, 4'h0, 2'd1, '0, '0, 32'd20, '0, 7'd0), 1'b0);
    send(make_req(ReqStore, '0, 4'h0, 2'd3, '0, '0, 32'd0, '0, 7'd0), 1'b0);
    send(make_req(ReqStore, 64'h5, 4'h3, OriginFile, 64'h1, 64'h2, 32'd0, 16'd7, 7'd0), 1'b0);
    send(make_req(~ReqStore, '0, 4'h0, OriginFile, '0, '0, '0, '0, 7'd0), 1'b0);
    send(make_req(~ReqStore, 64'h5, 4'h3, 2'd2, '0, '0, '0, '0, 7'd63), 1'b0);
    clock_now = 32'hFFFF_FFF0;
    send(make_req(~ReqStore, '0, 4'h0, 2'd1, '0, '0, '0, '0, 7'd0), 1'b0);
    send(make_req(~ReqStore, 64'h5, 4'h3, 2'd1, '0, '0, '0, '0, 7'd0), 1'b0);
    send(make_req(~ReqStore, '1, 4'hF, 2'd1, '0, '0, '0, '0, 7'd1), 1'b0);

    // Hold off until the table is quiet once.
    drain();

    for (int n = 0; n < 1550; n++) begin
      if (n % 400 == 200) begin
        // Fill burst: distinct records until the table reports full, then a
        // time jump and a lookup that sweeps the expired ones away.
        for (int k = 0; k < 70; k++) begin
          clock_now += 1;
          send(make_req(ReqStore, rand64(), 4'($urandom()), 2'($urandom_range(1, 3)),
                        rand64(), rand64(), 32'd100, 16'($urandom()), 7'd0), 1'b1);
        end
        clock_now += 1000;
        send(make_req(~ReqStore, rand64(), 4'h0, 2'd1, '0, '0, '0, '0, 7'd0), 1'b1);
        fill_bursts++;
      end else begin
        r = random_req();
        send(r, $urandom_range(0, 3) != 0);
      end
    end

    while (pending != 0) @(negedge clk_i);
    repeat (140) @(negedge clk_i);
    $display("Ran %0d fill bursts: %0d hits, %0d full replies, %0d expiries, %0d refreshes.",
             fill_bursts, hit_count, full_count, expire_count, refresh_count);
    if (fail_count == 0 && pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
hw/rtl/ttlrc_pkg.sv
hw/rtl/ttlrc_cell.sv
hw/rtl/ttlrc_head.sv
hw/rtl/ttl_record_cache_table.sv
dv/ttl_record_cache_table_checker.sv
dv/ttl_record_cache_table_tb.sv
